/* rtl/upd_pkg.sv */
package upd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    typedef enum logic [2:0] {
        KIND_NAME_BYTE  = 3'd0,
        KIND_VALUE_BYTE = 3'd1,
        KIND_NAME_END   = 3'd2,
        KIND_VALUE_END  = 3'd3,
        KIND_NAME_DROP  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2,
        ESC_NONE = 2'd3
    } esc_t;

    // One queue entry holds the words caused by one input byte.
    typedef struct packed {
        logic       two;
        kind_t      kind0;
        logic [7:0] byte0;
        kind_t      kind1;
    } upd_entry_t;

    function automatic logic [3:0] hex_of(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h41 + 8'd10);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h61 + 8'd10);
        end
        return v;
    endfunction

endpackage

/* rtl/upd_front.sv */
module upd_front
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] raw_byte,
    input  logic       end_of_string,
    input  logic       q_full,
    output logic       q_push,
    output upd_entry_t q_entry
);

    logic       in_value_reg;
    logic       in_value_next;
    esc_t       esc_reg;
    esc_t       esc_next;
    logic [3:0] nib_reg;
    logic [3:0] nib_next;

    logic       accept;
    logic       dec_valid;
    logic [7:0] dec_byte;
    esc_t       dec_esc;
    logic [3:0] dec_nib;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        dec_valid = 1'b0;
        dec_byte  = 8'd0;
        dec_esc   = ESC_IDLE;
        dec_nib   = nib_reg;
        case (esc_reg)
            ESC_HIGH:
            begin
                dec_nib = hex_of(raw_byte);
                dec_esc = ESC_LOW;
            end
            ESC_LOW:
            begin
                dec_valid = 1'b1;
                dec_byte  = {nib_reg, hex_of(raw_byte)};
                dec_nib   = 4'd0;
            end
            default:
            begin
                if (raw_byte == CHAR_PERCENT) begin
                    dec_esc = ESC_HIGH;
                end
                else begin
                    dec_valid = 1'b1;
                    dec_byte  = (raw_byte == CHAR_PLUS) ? CHAR_SPACE : raw_byte;
                end
            end
        endcase
    end

    always_comb
    begin
        in_value_next = in_value_reg;
        esc_next      = esc_reg;
        nib_next      = nib_reg;
        q_push        = 1'b0;
        q_entry.two   = 1'b0;
        q_entry.kind0 = KIND_NAME_BYTE;
        q_entry.byte0 = 8'd0;
        q_entry.kind1 = KIND_NAME_DROP;
        if (accept) begin
            if (!in_value_reg && raw_byte == CHAR_EQUALS) begin
                q_push        = 1'b1;
                q_entry.kind0 = KIND_NAME_END;
                q_entry.two   = end_of_string;
                q_entry.kind1 = KIND_VALUE_END;
                esc_next      = ESC_IDLE;
                nib_next      = 4'd0;
                in_value_next = 1'b1;
            end
            else if (in_value_reg && raw_byte == CHAR_AMP) begin
                q_push        = 1'b1;
                q_entry.kind0 = KIND_VALUE_END;
                esc_next      = ESC_IDLE;
                nib_next      = 4'd0;
                in_value_next = 1'b0;
            end
            else begin
                esc_next      = dec_esc;
                nib_next      = dec_nib;
                q_entry.kind1 = in_value_reg ? KIND_VALUE_END : KIND_NAME_DROP;
                if (dec_valid) begin
                    q_push        = 1'b1;
                    q_entry.kind0 = in_value_reg ? KIND_VALUE_BYTE : KIND_NAME_BYTE;
                    q_entry.byte0 = dec_byte;
                    q_entry.two   = end_of_string;
                end
                else if (end_of_string) begin
                    q_push        = 1'b1;
                    q_entry.kind0 = in_value_reg ? KIND_VALUE_END : KIND_NAME_DROP;
                end
            end
            if (end_of_string) begin
                in_value_next = 1'b0;
                esc_next      = ESC_IDLE;
                nib_next      = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_value_reg <= 1'b0;
            esc_reg      <= ESC_IDLE;
            nib_reg      <= 4'd0;
        end
        else begin
            in_value_reg <= in_value_next;
            esc_reg      <= esc_next;
            nib_reg      <= nib_next;
        end
    end

`ifndef SYNTHESIS
    a_no_phase3: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg != ESC_NONE)
        else $error("escape phase reached the unused code");
    a_eos_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_string |=> !in_value_reg && esc_reg == ESC_IDLE)
        else $error("state not cleared after end of string");
`endif

endmodule

/* rtl/upd_fifo.sv */
module upd_fifo
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  upd_entry_t wr_entry,
    output logic       full,
    input  logic       pop,
    output upd_entry_t rd_entry,
    output logic       empty
);

    upd_entry_t             mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");
`endif

endmodule

/* rtl/upd_back.sv */
module upd_back
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  upd_entry_t q_entry,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] out_byte,
    output logic       last
);

    logic       valid_reg;
    logic       valid_next;
    logic       pend_reg;
    logic       pend_next;
    kind_t      pend_kind_reg;
    kind_t      kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       advance;

    assign advance   = !valid_reg || !out_stall;
    assign q_pop     = advance && !pend_reg && !q_empty;
    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = byte_reg;
    assign last      = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        if (advance) begin
            if (pend_reg) begin
                valid_next = 1'b1;
                pend_next  = 1'b0;
            end
            else begin
                valid_next = !q_empty;
                pend_next  = !q_empty && q_entry.two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            if (pend_reg) begin
                kind_reg <= pend_kind_reg;
                byte_reg <= 8'd0;
                last_reg <= 1'b1;
            end
            else if (!q_empty) begin
                kind_reg      <= q_entry.kind0;
                byte_reg      <= q_entry.byte0;
                last_reg      <= !q_entry.two;
                pend_kind_reg <= q_entry.kind1;
            end
        end
    end

`ifndef SYNTHESIS
    a_pend_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> valid_reg && !last_reg)
        else $error("second word pending without a first word in the output");
`endif

endmodule

/* rtl/urlencoded_pair_decoder.sv */
// Decodes a name=value&name=value byte stream, one raw byte per cycle at the input
// while the queue is not full. Each byte yields zero, one or two output words
// (decoded name or value bytes and end-of-name, end-of-value and name-dropped
// markers); last marks the final word of a byte. The front classifies a byte in its
// accept cycle and writes its words as one entry into a four-entry queue; the back
// sends them through a single output register, one word per cycle while out_stall
// is low. Throughput is one byte per cycle while nothing stalls and bytes give at
// most one word each; a byte that gives two words holds the output register while
// its second word waits, and the queue absorbs short runs of such bytes.
module urlencoded_pair_decoder
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] raw_byte,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] out_byte,
    output logic       last
);

    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    upd_entry_t q_wr_entry;
    upd_entry_t q_rd_entry;

    upd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .raw_byte      (raw_byte),
        .end_of_string (end_of_string),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_wr_entry)
    );

    upd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .empty    (q_empty)
    );

    upd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_entry   (q_rd_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

/* sim/pair_decode_checker.sv */
module pair_decode_checker
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] raw_byte,
    input  logic       end_of_string,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] kind,
    input  logic [7:0] out_byte,
    input  logic       last,
    output int         fail_count,
    output int         pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        kind_t      kind;
        logic [7:0] value;
        logic       tail;
    } decoded_word_t;

    decoded_word_t decoded_words_due[$];

    logic       in_value_q  = 1'b0;
    esc_t       esc_phase   = ESC_IDLE;
    logic [3:0] high_nibble = 4'd0;

    initial
    begin
        fail_count = 0;
        pending_words = 0;
    end

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            d = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            d = c[3:0] + 4'd9;
        end
        return d;
    endfunction

    function automatic decoded_word_t make_word(input kind_t k, input logic [7:0] v);
        decoded_word_t w;
        w.kind = k;
        w.value = v;
        w.tail = 1'b0;
        return w;
    endfunction

    // Runs one data character through the escape decoder.
    task automatic decode_char(input logic [7:0] c, output logic got, output logic [7:0] dec);
        got = 1'b0;
        dec = 8'd0;
        case (esc_phase)
            ESC_HIGH:
            begin
                high_nibble = hex_digit(c);
                esc_phase = ESC_LOW;
            end
            ESC_LOW:
            begin
                dec = {high_nibble, hex_digit(c)};
                got = 1'b1;
                esc_phase = ESC_IDLE;
                high_nibble = 4'd0;
            end
            default:
            begin
                esc_phase = ESC_IDLE;
                if (c == CHAR_PERCENT)
                begin
                    esc_phase = ESC_HIGH;
                end
                else
                begin
                    dec = (c == CHAR_PLUS) ? CHAR_SPACE : c;
                    got = 1'b1;
                end
            end
        endcase
    endtask

    task automatic decode_raw_byte(input logic [7:0] c, input logic eos);
        decoded_word_t made[2];
        int n;
        logic got;
        logic [7:0] dec;
        n = 0;
        if (!in_value_q)
        begin
            if (c == CHAR_EQUALS)
            begin
                made[n] = make_word(KIND_NAME_END, 8'd0);
                n++;
                esc_phase = ESC_IDLE;
                high_nibble = 4'd0;
                in_value_q = 1'b1;
                if (eos)
                begin
                    made[n] = make_word(KIND_VALUE_END, 8'd0);
                    n++;
                end
            end
            else
            begin
                decode_char(c, got, dec);
                if (got)
                begin
                    made[n] = make_word(KIND_NAME_BYTE, dec);
                    n++;
                end
                if (eos)
                begin
                    made[n] = make_word(KIND_NAME_DROP, 8'd0);
                    n++;
                end
            end
        end
        else
        begin
            if (c == CHAR_AMP)
            begin
                made[n] = make_word(KIND_VALUE_END, 8'd0);
                n++;
                esc_phase = ESC_IDLE;
                high_nibble = 4'd0;
                in_value_q = 1'b0;
            end
            else
            begin
                decode_char(c, got, dec);
                if (got)
                begin
                    made[n] = make_word(KIND_VALUE_BYTE, dec);
                    n++;
                end
                if (eos)
                begin
                    made[n] = make_word(KIND_VALUE_END, 8'd0);
                    n++;
                end
            end
        end
        if (eos)
        begin
            in_value_q = 1'b0;
            esc_phase = ESC_IDLE;
            high_nibble = 4'd0;
        end
        if (n > 0)
        begin
            made[n - 1].tail = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            decoded_words_due.push_back(made[i]);
        end
    endtask

    task automatic compare_word();
        decoded_word_t w;
        if (decoded_words_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("Unexpected word: kind %0d byte %02h last %0b", kind, out_byte, last);
            end
        end
        else
        begin
            w = decoded_words_due.pop_front();
            if (kind !== w.kind || out_byte !== w.value || last !== w.tail)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display({"Mismatch: expected kind %0d byte %02h last %0b, ",
                              "got kind %0d byte %02h last %0b"},
                             w.kind, w.value, w.tail, kind, out_byte, last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_value_q = 1'b0;
            esc_phase = ESC_IDLE;
            high_nibble = 4'd0;
            decoded_words_due.delete();
            pending_words <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_raw_byte(raw_byte, end_of_string);
            end
            if (out_valid && !out_stall)
            begin
                compare_word();
            end
            pending_words <= decoded_words_due.size();
        end
    end

endmodule

/* sim/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import upd_pkg::*;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [7:0] raw_byte      = 8'd0;
    logic       end_of_string = 1'b0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       last;
    int         fail_count;
    int         pending_words;

    logic       calm = 1'b0;
    int         bytes_sent = 0;
    logic [7:0] encoded_text[$];

    urlencoded_pair_decoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .raw_byte(raw_byte),
        .end_of_string(end_of_string),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .out_byte(out_byte),
        .last(last)
    );

    pair_decode_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .raw_byte(raw_byte),
        .end_of_string(end_of_string),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .out_byte(out_byte),
        .last(last),
        .fail_count(fail_count),
        .pending_words(pending_words)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 18);
    end

    initial
    begin
        #300000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_word(input logic [7:0] b, input logic eos);
        while (!calm && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_byte <= b;
        end_of_string <= eos;
        @(negedge clk);
        while (in_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < encoded_text.size(); i++)
        begin
            send_word(encoded_text[i], i == encoded_text.size() - 1);
        end
        encoded_text.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            encoded_text.push_back(s[i]);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_words != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789ABCDEFabcdef";
        if ($urandom_range(9) == 0)
        begin
            return 8'($urandom_range(255));
        end
        return digits[$urandom_range(21)];
    endfunction

    task automatic add_field_char(input logic in_val);
        string plain;
        int pick;
        plain = "abcxyzAZQ09_-.~";
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            encoded_text.push_back(plain[$urandom_range(plain.len() - 1)]);
        end
        else if (pick < 50)
        begin
            encoded_text.push_back(CHAR_PLUS);
        end
        else if (pick < 75)
        begin
            encoded_text.push_back(CHAR_PERCENT);
            encoded_text.push_back(hex_char());
            encoded_text.push_back(hex_char());
        end
        else if (pick < 82)
        begin
            // An escape left incomplete here; a following delimiter cuts it short, other characters complete it.
            encoded_text.push_back(CHAR_PERCENT);
            if ($urandom_range(1))
            begin
                encoded_text.push_back(hex_char());
            end
        end
        else if (pick < 92)
        begin
            encoded_text.push_back(8'($urandom_range(255)));
        end
        else
        begin
            encoded_text.push_back(in_val ? CHAR_EQUALS : CHAR_AMP);
        end
    endtask

    task automatic make_pairs();
        int pairs;
        int ending;
        pairs = $urandom_range(1, 4);
        for (int p = 0; p < pairs; p++)
        begin
            repeat ($urandom_range(0, 5)) add_field_char(1'b0);
            encoded_text.push_back(CHAR_EQUALS);
            repeat ($urandom_range(0, 6)) add_field_char(1'b1);
            if (p != pairs - 1)
            begin
                encoded_text.push_back(CHAR_AMP);
            end
        end
        ending = $urandom_range(9);
        if (ending == 0)
        begin
            encoded_text.push_back(CHAR_AMP);
        end
        else if (ending == 1)
        begin
            encoded_text.push_back(CHAR_AMP);
            repeat ($urandom_range(1, 4)) add_field_char(1'b0);
        end
    endtask

    task automatic make_noise();
        repeat ($urandom_range(1, 12))
        begin
            if ($urandom_range(9) < 3)
            begin
                case ($urandom_range(3))
                    0: encoded_text.push_back(CHAR_EQUALS);
                    1: encoded_text.push_back(CHAR_AMP);
                    2: encoded_text.push_back(CHAR_PERCENT);
                    default: encoded_text.push_back(CHAR_PLUS);
                endcase
            end
            else
            begin
                encoded_text.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        logic drained;
        drained = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_text("%Fg=");
        send_text();
        add_text("&=%z&");
        send_text();
        add_text("+");
        encoded_text.push_back(8'h00);
        add_text("=a=");
        encoded_text.push_back(8'hFF);
        add_text("%");
        send_text();
        add_text("%%&x");
        send_text();
        add_text("a%4=b");
        send_text();

        while (bytes_sent < 1076)
        begin
            calm = (bytes_sent >= 350 && bytes_sent < 550);
            if (!drained && bytes_sent >= 700)
            begin
                wait_drained();
                drained = 1'b1;
            end
            if ($urandom_range(99) < 15)
            begin
                make_noise();
            end
            else
            begin
                make_pairs();
            end
            send_text();
        end
        calm = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
